[design/i2cee_pkg.sv]
// Package for the I2C EEPROM byte access master.
// Holds sequence step codes, the sequencer state and bus result types, and helpers.
// No dependencies.
`default_nettype none

package i2cee_pkg;

  localparam int StepW = 4;

  localparam logic [StepW-1:0] ST_IDLE     = 4'd0;
  localparam logic [StepW-1:0] ST_START    = 4'd1;
  localparam logic [StepW-1:0] ST_DEVW     = 4'd2;
  localparam logic [StepW-1:0] ST_DEVW_ACK = 4'd3;
  localparam logic [StepW-1:0] ST_ADRH     = 4'd4;
  localparam logic [StepW-1:0] ST_ADRH_ACK = 4'd5;
  localparam logic [StepW-1:0] ST_ADRL     = 4'd6;
  localparam logic [StepW-1:0] ST_ADRL_ACK = 4'd7;
  localparam logic [StepW-1:0] ST_DATA     = 4'd8;
  localparam logic [StepW-1:0] ST_DATA_ACK = 4'd9;
  localparam logic [StepW-1:0] ST_RESTART  = 4'd10;
  localparam logic [StepW-1:0] ST_DEVR     = 4'd11;
  localparam logic [StepW-1:0] ST_DEVR_ACK = 4'd12;
  localparam logic [StepW-1:0] ST_RECV     = 4'd13;
  localparam logic [StepW-1:0] ST_MNACK    = 4'd14;
  localparam logic [StepW-1:0] ST_STOP     = 4'd15;

  // Configuration register indexes
  localparam logic CFG_PHASE_TICKS = 1'b0;
  localparam logic CFG_DEV_ADDR    = 1'b1;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd50;
  localparam logic [6:0]  DEV_ADDR_RST    = 7'h50;

  typedef struct packed {
    logic [StepW-1:0] step;
    logic [1:0]       quarter;
    logic [2:0]       bit_cnt;
    logic [7:0]       shift;
    logic [15:0]      addr;
    logic [7:0]       data;
    logic             func;
    logic [7:0]       rx;
    logic             err;
  } seq_state_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack_error;
  } bus_res_t;

  function automatic logic is_send(input logic [StepW-1:0] s);
    return (s == ST_DEVW) || (s == ST_ADRH) || (s == ST_ADRL) || (s == ST_DATA) ||
           (s == ST_DEVR);
  endfunction

  function automatic logic is_ack(input logic [StepW-1:0] s);
    return (s == ST_DEVW_ACK) || (s == ST_ADRH_ACK) || (s == ST_ADRL_ACK) ||
           (s == ST_DATA_ACK) || (s == ST_DEVR_ACK);
  endfunction

endpackage

`default_nettype wire

[design/i2cee_if.sv]
// Valid/ready channel interfaces for the I2C EEPROM byte access master.
// Depends on nothing; one interface for requests in, one for bus results out.
`default_nettype none

interface i2cee_in_if;
  logic        valid;
  logic        ready;
  logic        req_valid;
  logic        func;
  logic [15:0] mem_address;
  logic [7:0]  write_data;
  logic        sda_in;

  modport source (output valid, req_valid, func, mem_address, write_data, sda_in,
                  input ready);
  modport sink (input valid, req_valid, func, mem_address, write_data, sda_in,
                output ready);
endinterface

interface i2cee_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       nack_error;

  modport source (output valid, scl_level, sda_drive_low, busy_res, done_res, read_data,
                  nack_error, input ready);
  modport sink (input valid, scl_level, sda_drive_low, busy_res, done_res, read_data,
                nack_error, output ready);
endinterface

`default_nettype wire

[design/i2cee_step.sv]
// One tick of the I2C EEPROM bus sequencer: next state and bus levels.
// Purely combinational; uses i2cee_pkg.
`default_nettype none

module i2cee_step #(
  parameter int TICK_COUNT_BITS = 16
) (
  input  wire i2cee_pkg::seq_state_t cur,
  input  wire [TICK_COUNT_BITS-1:0]  tick,
  input  wire [15:0]                 phase_ticks,
  input  wire [6:0]                  dev_addr,
  input  wire                        req_valid,
  input  wire                        func,
  input  wire [15:0]                 mem_address,
  input  wire [7:0]                  write_data,
  input  wire                        sda_in,
  output i2cee_pkg::seq_state_t      nxt,
  output logic [TICK_COUNT_BITS-1:0] tick_nxt,
  output i2cee_pkg::bus_res_t        res
);

  localparam int CW = ((TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16) + 1;

  logic [CW-1:0] tick_inc;
  logic [CW-1:0] lim_raw;
  logic [CW-1:0] lim_cap;
  logic [CW-1:0] lim;
  logic          qend;
  logic          done;

  assign tick_inc = CW'(tick) + CW'(1);
  assign lim_raw  = (phase_ticks == 16'd0) ? CW'(1) : CW'(phase_ticks);
  assign lim_cap  = CW'(1) << TICK_COUNT_BITS;
  assign lim      = (lim_raw > lim_cap) ? lim_cap : lim_raw;
  assign qend     = (tick_inc >= lim);

  always_comb begin
    nxt      = cur;
    tick_nxt = tick;
    done     = 1'b0;
    if (cur.step == i2cee_pkg::ST_IDLE) begin
      if (req_valid) begin
        nxt.func    = func;
        nxt.addr    = mem_address;
        nxt.data    = write_data;
        nxt.err     = 1'b0;
        if (func) begin
          nxt.rx = 8'd0;
        end
        nxt.step    = i2cee_pkg::ST_START;
        nxt.quarter = 2'd0;
        nxt.bit_cnt = 3'd0;
        tick_nxt    = '0;
      end
    end else begin
      // Sample SDA at the last tick of the second high quarter
      if (qend && (cur.quarter == 2'd2)) begin
        if (i2cee_pkg::is_ack(cur.step) && sda_in) begin
          nxt.err = 1'b1;
        end
        if (cur.step == i2cee_pkg::ST_RECV) begin
          nxt.shift = {cur.shift[6:0], sda_in};
        end
      end
      if (!qend) begin
        tick_nxt = tick_inc[TICK_COUNT_BITS-1:0];
      end else begin
        tick_nxt = '0;
        if (cur.quarter != 2'd3) begin
          nxt.quarter = cur.quarter + 2'd1;
        end else begin
          nxt.quarter = 2'd0;
          if (i2cee_pkg::is_send(cur.step)) begin
            nxt.shift   = {cur.shift[6:0], 1'b0};
            nxt.bit_cnt = cur.bit_cnt + 3'd1;
            if (cur.bit_cnt == 3'd7) begin
              nxt.step = cur.step + i2cee_pkg::StepW'(1);
            end
          end else if (i2cee_pkg::is_ack(cur.step) && cur.err) begin
            nxt.step = i2cee_pkg::ST_STOP;
          end else begin
            unique case (cur.step)
              i2cee_pkg::ST_START: begin
                nxt.step    = i2cee_pkg::ST_DEVW;
                nxt.bit_cnt = 3'd0;
                nxt.shift   = {dev_addr, 1'b0};
              end
              i2cee_pkg::ST_DEVW_ACK: begin
                nxt.step    = i2cee_pkg::ST_ADRH;
                nxt.bit_cnt = 3'd0;
                nxt.shift   = cur.addr[15:8];
              end
              i2cee_pkg::ST_ADRH_ACK: begin
                nxt.step    = i2cee_pkg::ST_ADRL;
                nxt.bit_cnt = 3'd0;
                nxt.shift   = cur.addr[7:0];
              end
              i2cee_pkg::ST_ADRL_ACK: begin
                if (cur.func) begin
                  nxt.step = i2cee_pkg::ST_RESTART;
                end else begin
                  nxt.step    = i2cee_pkg::ST_DATA;
                  nxt.bit_cnt = 3'd0;
                  nxt.shift   = cur.data;
                end
              end
              i2cee_pkg::ST_DATA_ACK: nxt.step = i2cee_pkg::ST_STOP;
              i2cee_pkg::ST_RESTART: begin
                nxt.step    = i2cee_pkg::ST_DEVR;
                nxt.bit_cnt = 3'd0;
                nxt.shift   = {dev_addr, 1'b1};
              end
              i2cee_pkg::ST_DEVR_ACK: begin
                nxt.step    = i2cee_pkg::ST_RECV;
                nxt.bit_cnt = 3'd0;
                nxt.shift   = 8'd0;
              end
              i2cee_pkg::ST_RECV: begin
                nxt.bit_cnt = cur.bit_cnt + 3'd1;
                if (cur.bit_cnt == 3'd7) begin
                  nxt.rx   = cur.shift;
                  nxt.step = i2cee_pkg::ST_MNACK;
                end
              end
              i2cee_pkg::ST_MNACK: nxt.step = i2cee_pkg::ST_STOP;
              default: begin
                nxt.step = i2cee_pkg::ST_IDLE;
                done     = 1'b1;
              end
            endcase
          end
        end
      end
    end
  end

  // Bus levels from the updated state
  always_comb begin
    res.scl_level     = 1'b1;
    res.sda_drive_low = 1'b0;
    if (nxt.step != i2cee_pkg::ST_IDLE) begin
      res.scl_level = (nxt.quarter == 2'd1) || (nxt.quarter == 2'd2);
      if ((nxt.step == i2cee_pkg::ST_START) || (nxt.step == i2cee_pkg::ST_RESTART)) begin
        res.sda_drive_low = nxt.quarter[1];
      end else if (nxt.step == i2cee_pkg::ST_STOP) begin
        res.scl_level     = (nxt.quarter != 2'd0);
        res.sda_drive_low = !nxt.quarter[1];
      end else if (i2cee_pkg::is_send(nxt.step)) begin
        res.sda_drive_low = !nxt.shift[7];
      end
    end
    res.busy_res   = (nxt.step != i2cee_pkg::ST_IDLE);
    res.done_res   = done;
    res.read_data  = nxt.rx;
    res.nack_error = nxt.err;
  end

endmodule

`default_nettype wire

[design/i2c_eeprom_byte_access_master.sv]
// Top level of the I2C master for two-byte-addressed EEPROMs.
// Uses i2cee_pkg, the channel interfaces in i2cee_if.sv and the sequencer i2cee_step.
`default_nettype none

// Every request on the input channel is one tick of the bus sequencer: it may
// carry a new access (taken only while idle) and always carries the sampled
// SDA level. Each request yields exactly one result with the SCL/SDA levels
// to drive after that tick, busy/done status, the last read byte and the
// NACK flag. The block takes one request per clock cycle unless the sink holds
// a waiting result: the sequencer update is a single combinational pass from
// the state registers into the result register, and in_chan.ready stays high
// while the result register is empty or being drained, so a waiting result
// stalls the input only while the sink holds it. A write access spans
// 1 + 4*9 + STOP slots, a read 1 + 3*9 + 1 + 9 + 8 + 1 + STOP slots, each
// slot four quarters of phase_ticks requests (zero counts as one). A missing
// acknowledge sets nack_error, sends STOP after that slot, finishes with done.
// Write the configuration registers only while no access is in progress.

module i2c_eeprom_byte_access_master #(
  parameter int TICK_COUNT_BITS = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  i2cee_in_if.sink   in_chan,
  i2cee_out_if.source out_chan,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [15:0] cfg_wdata
);

  // Configuration registers
  logic [15:0] phase_ticks_r;
  logic [6:0]  dev_addr_r;

  // Sequencer state
  i2cee_pkg::seq_state_t        state_r;
  i2cee_pkg::seq_state_t        state_nxt;
  logic [TICK_COUNT_BITS-1:0]   tick_r;
  logic [TICK_COUNT_BITS-1:0]   tick_nxt;

  // Result register
  i2cee_pkg::bus_res_t res_nxt;
  i2cee_pkg::bus_res_t res_r;
  logic                out_valid_r;

  logic in_take;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cee_pkg::PHASE_TICKS_RST;
      dev_addr_r    <= i2cee_pkg::DEV_ADDR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cee_pkg::CFG_PHASE_TICKS: phase_ticks_r <= cfg_wdata;
        i2cee_pkg::CFG_DEV_ADDR:    dev_addr_r    <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  i2cee_step #(
    .TICK_COUNT_BITS(TICK_COUNT_BITS)
  ) u_step (
    .cur         (state_r),
    .tick        (tick_r),
    .phase_ticks (phase_ticks_r),
    .dev_addr    (dev_addr_r),
    .req_valid   (in_chan.req_valid),
    .func        (in_chan.func),
    .mem_address (in_chan.mem_address),
    .write_data  (in_chan.write_data),
    .sda_in      (in_chan.sda_in),
    .nxt         (state_nxt),
    .tick_nxt    (tick_nxt),
    .res         (res_nxt)
  );

  // Advance the sequencer and load the result on every accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        state_r     <= state_nxt;
        tick_r      <= tick_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.scl_level     = res_r.scl_level;
  assign out_chan.sda_drive_low = res_r.sda_drive_low;
  assign out_chan.busy_res      = res_r.busy_res;
  assign out_chan.done_res      = res_r.done_res;
  assign out_chan.read_data     = res_r.read_data;
  assign out_chan.nack_error    = res_r.nack_error;

  // A finished access reports done with busy already dropped
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.done_res |-> !res_r.busy_res)
    else $error("done reported while busy");

  // An idle bus is released on both lines
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.busy_res |-> res_r.scl_level && !res_r.sda_drive_low)
    else $error("bus driven while idle");

  // A request taken while idle starts an access with a clean error flag
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && (state_r.step == i2cee_pkg::ST_IDLE) && in_chan.req_valid
    |=> out_valid_r && res_r.busy_res && !res_r.nack_error)
    else $error("access did not start");

  // The tick counter and the step stay put while no request is taken
  a_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_take |=> $stable(tick_r) && $stable(state_r.step))
    else $error("sequencer moved without a request");

endmodule

`default_nettype wire

[sim/i2cee_checker.sv]
// Scoreboard for the I2C EEPROM byte access master: predicts every bus result.
// Depends on i2cee_pkg and the channel interfaces in i2cee_if.sv.
`timescale 1ns / 1ps

module i2cee_checker (
  input  wire        clk,
  input  wire        rst_n,
  i2cee_in_if        in_mon,
  i2cee_out_if       out_mon,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [15:0] cfg_wdata,
  output int         errors,
  output int         pending,
  output logic       seq_busy
);
  import i2cee_pkg::*;

  localparam int MAX_REPORTS = 30;

  bus_res_t         bus_expect_q[$];
  int               mismatches;

  // configuration copy
  logic [15:0]      phase_cfg;
  logic [6:0]       dev_cfg;

  // sequencer state as the predictor sees it
  logic [StepW-1:0] pstep;
  logic [1:0]       pquarter;
  logic [15:0]      pticks;
  logic [3:0]       pbits;
  logic [7:0]       pshift;
  logic [15:0]      paddr;
  logic [7:0]       pdata;
  logic             pfunc;
  logic [7:0]       prx;
  logic             pnack;

  function automatic logic sends_bits(input logic [StepW-1:0] s);
    return s inside {ST_DEVW, ST_ADRH, ST_ADRL, ST_DATA, ST_DEVR};
  endfunction

  function automatic logic awaits_ack(input logic [StepW-1:0] s);
    return s inside {ST_DEVW_ACK, ST_ADRH_ACK, ST_ADRL_ACK, ST_DATA_ACK, ST_DEVR_ACK};
  endfunction

  function automatic void load_byte(input logic [StepW-1:0] s);
    pstep = s;
    pbits = '0;
    case (s)
      ST_DEVW: pshift = {dev_cfg, 1'b0};
      ST_ADRH: pshift = paddr[15:8];
      ST_ADRL: pshift = paddr[7:0];
      ST_DATA: pshift = pdata;
      default: pshift = {dev_cfg, 1'b1};
    endcase
  endfunction

  // Close the current bit slot; returns 1 when the access is over.
  function automatic logic close_slot();
    if (sends_bits(pstep)) begin
      pshift = pshift << 1;
      pbits  = pbits + 4'd1;
      if (pbits >= 4'd8) begin
        pbits = '0;
        pstep = pstep + 1'b1;
      end
      return 1'b0;
    end
    if (awaits_ack(pstep) && pnack) begin
      pstep = ST_STOP;
      return 1'b0;
    end
    case (pstep)
      ST_START:    load_byte(ST_DEVW);
      ST_DEVW_ACK: load_byte(ST_ADRH);
      ST_ADRH_ACK: load_byte(ST_ADRL);
      ST_ADRL_ACK: begin
        if (pfunc) pstep = ST_RESTART;
        else load_byte(ST_DATA);
      end
      ST_DATA_ACK: pstep = ST_STOP;
      ST_RESTART:  load_byte(ST_DEVR);
      ST_DEVR_ACK: begin
        pstep  = ST_RECV;
        pbits  = '0;
        pshift = '0;
      end
      ST_RECV: begin
        pbits = pbits + 4'd1;
        if (pbits >= 4'd8) begin
          prx   = pshift;
          pbits = '0;
          pstep = ST_MNACK;
        end
      end
      ST_MNACK: pstep = ST_STOP;
      default: begin
        pstep = ST_IDLE;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // Advance the predicted sequencer by one tick and give the bus result after it.
  function automatic bus_res_t bus_after_tick(input logic req, input logic fn,
                                              input logic [15:0] addr,
                                              input logic [7:0] data, input logic sda);
    logic        fin;
    logic        qend;
    logic [16:0] qlen;
    bus_res_t    r;
    fin = 1'b0;
    if (pstep == ST_IDLE) begin
      if (req) begin
        pfunc    = fn;
        paddr    = addr;
        pdata    = data;
        pnack    = 1'b0;
        if (fn) prx = '0;
        pstep    = ST_START;
        pquarter = '0;
        pticks   = '0;
        pbits    = '0;
      end
    end else begin
      qlen = (phase_cfg == '0) ? 17'd1 : {1'b0, phase_cfg};
      qend = ({1'b0, pticks} + 17'd1) >= qlen;
      if (qend && pquarter == 2'd2) begin
        if (awaits_ack(pstep) && sda) pnack = 1'b1;
        if (pstep == ST_RECV) pshift = {pshift[6:0], sda};
      end
      if (!qend) begin
        pticks = pticks + 16'd1;
      end else begin
        pticks = '0;
        if (pquarter != 2'd3) begin
          pquarter = pquarter + 2'd1;
        end else begin
          pquarter = '0;
          fin = close_slot();
        end
      end
    end
    r.scl_level     = 1'b1;
    r.sda_drive_low = 1'b0;
    if (pstep != ST_IDLE) begin
      r.scl_level = (pquarter == 2'd1) || (pquarter == 2'd2);
      if (pstep == ST_START || pstep == ST_RESTART) begin
        r.sda_drive_low = pquarter >= 2'd2;
      end else if (pstep == ST_STOP) begin
        r.scl_level     = pquarter != 2'd0;
        r.sda_drive_low = pquarter <= 2'd1;
      end else if (sends_bits(pstep)) begin
        r.sda_drive_low = !pshift[7];
      end
    end
    r.busy_res   = pstep != ST_IDLE;
    r.done_res   = fin;
    r.read_data  = prx;
    r.nack_error = pnack;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    bus_res_t want;
    if (!rst_n) begin
      bus_expect_q.delete();
      mismatches = 0;
      phase_cfg  = PHASE_TICKS_RST;
      dev_cfg    = DEV_ADDR_RST;
      pstep      = ST_IDLE;
      pquarter   = '0;
      pticks     = '0;
      pbits      = '0;
      pshift     = '0;
      paddr      = '0;
      pdata      = '0;
      pfunc      = 1'b0;
      prx        = '0;
      pnack      = 1'b0;
    end else begin
      // compare first: a result never belongs to a request taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (bus_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result expected none got scl %b sda_low %b busy %b",
                     $time, out_mon.scl_level, out_mon.sda_drive_low, out_mon.busy_res);
        end else begin
          want = bus_expect_q.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(out_mon.scl_level));
          check_field("sda_drive_low", 8'(want.sda_drive_low), 8'(out_mon.sda_drive_low));
          check_field("busy_res", 8'(want.busy_res), 8'(out_mon.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(out_mon.done_res));
          check_field("read_data", want.read_data, out_mon.read_data);
          check_field("nack_error", 8'(want.nack_error), 8'(out_mon.nack_error));
        end
      end
      if (in_mon.valid && in_mon.ready)
        bus_expect_q.push_back(bus_after_tick(in_mon.req_valid, in_mon.func,
                                              in_mon.mem_address, in_mon.write_data,
                                              in_mon.sda_in));
      if (cfg_we) begin
        if (cfg_index == CFG_PHASE_TICKS) phase_cfg = cfg_wdata;
        else dev_cfg = cfg_wdata[6:0];
      end
    end
    errors   <= mismatches;
    pending  <= bus_expect_q.size();
    seq_busy <= pstep != ST_IDLE;
  end

endmodule

[sim/i2c_eeprom_byte_access_master_tb.sv]
// Testbench top for the I2C EEPROM byte access master: clock, reset, request
// stimulus with an EEPROM-like SDA responder, result sink and verdict.
// Depends on i2cee_pkg, i2cee_if.sv, the block itself and i2cee_checker.
`timescale 1ns / 1ps

module i2c_eeprom_byte_access_master_tb;
  import i2cee_pkg::*;

  // Bit slot numbers counted from the START slot (slot 0) of one access.
  localparam int ACK_DEVW    = 9;
  localparam int ACK_ADRH    = 18;
  localparam int ACK_ADRL    = 27;
  localparam int ACK_DATA    = 36;   // write only
  localparam int ACK_DEVR    = 37;   // read only
  localparam int RECV_FIRST  = 38;   // read: first of eight receive slots
  localparam int WRITE_SLOTS = 38;   // a clean write ends with the close of slot 37
  localparam int READ_SLOTS  = 48;   // a clean read ends with the close of slot 47
  localparam int NO_NACK     = -1;

  localparam logic FN_WRITE = 1'b0;
  localparam logic FN_READ  = 1'b1;

  localparam int RANDOM_TICKS     = 2000;
  localparam int RANDOM_ACCESSES  = 6;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES    = 8;
  localparam int CYCLE_LIMIT      = 3_000_000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;
  int          errors;
  int          pending;
  logic        seq_busy;
  logic        long_hold;  // ask the sink for one long hold-off
  logic        quiet;      // tail of the run: no idling on either side

  // stimulus-side bookkeeping
  logic [15:0] cur_phase;
  int          gap_odds;
  int          ticks_sent;
  int          hold_at;
  int          pause_at;

  i2cee_in_if  in_chan ();
  i2cee_out_if out_chan ();

  i2c_eeprom_byte_access_master uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  i2cee_checker bus_scoreboard (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_chan),
    .out_mon   (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending),
    .seq_busy  (seq_busy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request (one sequencer tick) and hold it until the block takes it.
  // A random idle gap may come first.
  task automatic send_tick(input logic req, input logic fn, input logic [15:0] addr,
                           input logic [7:0] data, input logic sda);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.req_valid   <= req;
    in_chan.func        <= fn;
    in_chan.mem_address <= addr;
    in_chan.write_data  <= data;
    in_chan.sda_in      <= sda;
    do @(posedge clk); while (!in_chan.ready);
    ticks_sent++;
  endtask

  // Drop valid and hold until every result is back; optionally also until the
  // sequencer has gone idle, which is what a register write needs.
  task automatic drain(input logic need_idle);
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending != 0 || (need_idle && seq_busy));
  endtask

  // Write both registers back to back while the block is idle.
  task automatic set_config(input logic [15:0] phase, input logic [15:0] dev);
    drain(1'b1);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PHASE_TICKS;
    cfg_wdata <= phase;
    @(posedge clk);
    cfg_index <= CFG_DEV_ADDR;
    cfg_wdata <= dev;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_phase = phase;
  endtask

  // Write only the phase register while the block is idle.
  task automatic set_phase(input logic [15:0] phase);
    drain(1'b1);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PHASE_TICKS;
    cfg_wdata <= phase;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_phase = phase;
  endtask

  // Ticks with no access: every field is noise except that no access starts.
  task automatic idle_ticks(input int n);
    repeat (n)
      send_tick(1'b0, 1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom),
                1'($urandom_range(0, 1)));
  endtask

  // One full access. The request tick comes first; the ticks after it play the
  // EEPROM side of SDA: at the sampling tick of each acknowledge slot drive ACK
  // (low) or, at the chosen slot, NACK (high); at the sampling ticks of the
  // receive slots drive the bits of rx_byte MSB first. Everything else on SDA
  // is noise, and now and then a request arrives that a busy block must ignore.
  // The access is over on its last tick, so the next tick may start another.
  task automatic run_access(input logic fn, input logic [15:0] addr,
                            input logic [7:0] data, input int nack_slot,
                            input logic [7:0] rx_byte);
    int   qlen;
    int   last;
    int   k;
    int   slot;
    int   pos;
    logic ack_slot;
    logic sda;
    qlen = (cur_phase == '0) ? 1 : int'(cur_phase);
    if (nack_slot != NO_NACK) last = (nack_slot + 2) * 4 * qlen;
    else last = (fn ? READ_SLOTS : WRITE_SLOTS) * 4 * qlen;
    send_tick(1'b1, fn, addr, data, 1'($urandom_range(0, 1)));
    for (k = 1; k <= last; k++) begin
      slot     = k / (4 * qlen);
      pos      = k % (4 * qlen);
      ack_slot = (slot == ACK_DEVW) || (slot == ACK_ADRH) || (slot == ACK_ADRL) ||
                 (slot == (fn ? ACK_DEVR : ACK_DATA));
      sda      = 1'($urandom_range(0, 1));
      if (pos == 3 * qlen) begin
        if (ack_slot) sda = (slot == nack_slot);
        else if (fn && slot >= RECV_FIRST && slot < RECV_FIRST + 8)
          sda = rx_byte[7 - (slot - RECV_FIRST)];
      end
      // one long hold-off on the result side while requests keep coming
      if (ticks_sent == hold_at) long_hold <= 1'b1;
      // one pause in mid access until every expected result is back
      if (ticks_sent == pause_at) drain(1'b0);
      if ($urandom_range(0, 15) == 0)
        send_tick(1'b1, 1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom), sda);
      else
        send_tick(1'b0, 1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom), sda);
    end
  endtask

  // Pick the slot that answers NACK, about one access in four.
  function automatic int pick_nack(input logic fn);
    if ($urandom_range(0, 3) != 0) return NO_NACK;
    case ($urandom_range(0, 3))
      0:       return ACK_DEVW;
      1:       return ACK_ADRH;
      2:       return ACK_ADRL;
      default: return fn ? ACK_DEVR : ACK_DATA;
    endcase
  endfunction

  // Result side: ready with random stall bursts, the stall rate drawn anew among three
  // settings (sometimes zero, for stretches with no stalls), plus the long hold-off
  // on request. Always ready in the tail.
  initial begin : result_sink
    int odds;
    int span;
    out_chan.ready <= 1'b0;
    odds = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        case ($urandom_range(0, 2))
          0:       odds = 0;
          1:       odds = 3;
          default: odds = 8;
        endcase
        span = 200;
      end
      span--;
      if (long_hold) begin
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold      <= 1'b0;
        out_chan.ready <= 1'b1;
      end else if (!quiet && odds != 0 && $urandom_range(1, odds) == 1) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Give up on a hung run.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("i2c_eeprom_byte_access_master_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int   accesses;
    logic fn;
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.req_valid   <= 1'b0;
    in_chan.func        <= 1'b0;
    in_chan.mem_address <= '0;
    in_chan.write_data  <= '0;
    in_chan.sda_in      <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_PHASE_TICKS;
    cfg_wdata           <= '0;
    long_hold           <= 1'b0;
    quiet               <= 1'b0;
    cur_phase  = PHASE_TICKS_RST;
    gap_odds   = 0;
    ticks_sent = 0;
    hold_at    = -1;
    pause_at   = -1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Fastest phase with the device address left at its reset
    // value; address and data extremes.
    set_phase(16'd1);
    run_access(FN_WRITE, 16'hFFFF, 8'hFF, NO_NACK, 8'h00);
    run_access(FN_READ, 16'h0000, 8'h00, NO_NACK, 8'hFF);
    idle_ticks(3);

    // Zero phase counts as one; top device address. NACK at every acknowledge,
    // reads first so that an aborted read follows a good one.
    set_config(16'd0, 16'h007F);
    run_access(FN_READ, 16'h5AA5, 8'h00, NO_NACK, 8'h81);
    run_access(FN_READ, 16'hA55A, 8'h00, ACK_DEVW, 8'hFF);
    run_access(FN_READ, 16'h0F0F, 8'h00, ACK_ADRH, 8'hFF);
    run_access(FN_READ, 16'hF0F0, 8'h00, ACK_ADRL, 8'hFF);
    run_access(FN_READ, 16'h3C3C, 8'h00, ACK_DEVR, 8'hFF);
    run_access(FN_WRITE, 16'hC3C3, 8'h5A, ACK_DATA, 8'h00);
    run_access(FN_WRITE, 16'h1111, 8'h22, ACK_DEVW, 8'h00);

    // Longest phase: only idle ticks, since an access would run far past the watchdog limit.
    // Upper bits of the device address write must be dropped.
    set_config(16'hFFFF, 16'hFF80);
    idle_ticks(12);

    // One read with a longer phase to exercise the quarter counter.
    set_config(16'd2, 16'h0050);
    run_access(FN_READ, 16'h7E81, 8'h00, NO_NACK, 8'h96);

    // Random part: mostly clean accesses with random content, the rest aborted.
    set_config(16'd1, 16'h002A);
    accesses = 0;
    while (ticks_sent < RANDOM_TICKS || accesses < RANDOM_ACCESSES) begin
      if (accesses % 4 == 3)
        set_config(16'($urandom_range(0, 1)), 16'($urandom));
      case ($urandom_range(0, 2))
        0:       gap_odds = 0;
        1:       gap_odds = 3;
        default: gap_odds = 8;
      endcase
      if (accesses == 2) hold_at = ticks_sent + 20;
      if (accesses == 5) pause_at = ticks_sent + 30;
      fn = 1'($urandom_range(0, 1));
      run_access(fn, 16'($urandom), 8'($urandom), pick_nack(fn), 8'($urandom));
      idle_ticks($urandom_range(0, 3));
      accesses++;
    end

    // Tail: no idling on either side.
    set_config(16'd1, 16'($urandom));
    quiet    <= 1'b1;
    gap_odds = 0;
    repeat (2) begin
      fn = 1'($urandom_range(0, 1));
      run_access(fn, 16'($urandom), 8'($urandom), NO_NACK, 8'($urandom));
    end

    drain(1'b0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("i2c_eeprom_byte_access_master_tb: done, clean");
    else
      $display("i2c_eeprom_byte_access_master_tb: done, errors");
    $finish;
  end

endmodule

[sim.f]
design/i2cee_pkg.sv
design/i2cee_if.sv
design/i2cee_step.sv
design/i2c_eeprom_byte_access_master.sv
sim/i2cee_checker.sv
sim/i2c_eeprom_byte_access_master_tb.sv
